[hw/rtl/mqcf_pkg.sv]
// ----------------------------------------------------------------------------
// Map query class filter package
// Shared types, unit operation codes, register indexes and the exp tables.
// ----------------------------------------------------------------------------
package mqcf_pkg;

	localparam int unsigned CLASS_COUNT = 3;
	localparam int unsigned EXP_ENTRIES = 256;
	localparam int unsigned EXP_W = 32;
	localparam int unsigned SERIES_TERMS = 16;
	localparam int unsigned DIV_STEPS = 17;
	localparam logic [8:0] EXP_CUTOFF = 9'd24;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_THR_DIVIDER = 3'd0;
	localparam logic [2:0] REG_THR_CROSSING = 3'd1;
	localparam logic [2:0] REG_THR_BOUNDARY = 3'd2;
	localparam logic [2:0] REG_CLASS_MASK = 3'd3;
	localparam logic [2:0] REG_X_MINIMUM = 3'd4;
	localparam logic [2:0] REG_Y_MINIMUM = 3'd5;
	localparam logic [2:0] REG_X_EXTENT = 3'd6;
	localparam logic [2:0] REG_Y_EXTENT = 3'd7;

	localparam logic [15:0] X_MINIMUM_RST = 16'hF100;
	localparam logic [15:0] Y_MINIMUM_RST = 16'hE200;
	localparam logic [15:0] X_EXTENT_RST = 16'h1E00;
	localparam logic [15:0] Y_EXTENT_RST = 16'h3C00;

	// Request kinds and result kinds.
	localparam logic CMD_DECISION = 1'b0;
	localparam logic CMD_POINT = 1'b1;
	localparam logic KIND_DECISION = 1'b0;
	localparam logic KIND_POINT = 1'b1;

	// Operations of the shared arithmetic unit.
	localparam logic [2:0] OP_NOP = 3'd0;
	localparam logic [2:0] OP_EXP_LOAD = 3'd1;
	localparam logic [2:0] OP_EXP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV_INIT = 3'd3;
	localparam logic [2:0] OP_DIV_STEP = 3'd4;
	localparam logic [2:0] OP_DN_MUL = 3'd5;
	localparam logic [2:0] OP_DN_FIN = 3'd6;

	typedef logic [EXP_ENTRIES*EXP_W-1:0] exp_tab_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  frac;
		logic        zero;
		logic        pos;
		logic        neg;
		logic [16:0] mag;
		logic [15:0] ext;
		logic [15:0] min;
	} unit_cmd_t;

	typedef struct packed {
		logic [16:0] quo;
		logic [15:0] dn;
	} unit_stat_t;

	// exp(-f/256) in Q1.31 from a truncated Taylor series, clamped to 0..1.
	function automatic logic [31:0] exp_series(input int unsigned f);
		longint          sum;
		longint unsigned mag;
		int unsigned     k;
		sum = 64'sh8000_0000;
		mag = 64'h8000_0000;
		for (k = 1; k <= SERIES_TERMS; k++) begin
			mag = (mag * 64'(f)) / 64'(256 * k);
			if (k[0])
				sum = sum - longint'(mag);
			else
				sum = sum + longint'(mag);
		end
		if (sum < 0)
			sum = 0;
		if (sum > 64'sh8000_0000)
			sum = 64'sh8000_0000;
		return sum[31:0];
	endfunction

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t t;
		for (int i = 0; i < EXP_ENTRIES; i++)
			t[i*EXP_W +: EXP_W] = exp_series(i);
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();
	localparam logic [31:0] EXP_ONE = exp_series(256);

endpackage

[hw/rtl/mqcf_unit.sv]
// ----------------------------------------------------------------------------
// Map query class filter shared arithmetic unit
// One multiplier and one restoring divider step, driven op by op by the
// sequencer: exp product chain, sigmoid division and point scaling.
// ----------------------------------------------------------------------------
module mqcf_unit import mqcf_pkg::*; (
	input  logic       clk,
	input  unit_cmd_t  ucmd,
	output unit_stat_t ustat
);

	logic [31:0] acc_q;
	logic [32:0] den_q;
	logic [32:0] rem_q;
	logic [16:0] num_lo_q;
	logic [16:0] quo_q;
	logic [31:0] prod_q;
	logic [15:0] dn_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] mul_rnd;
	logic [32:0] den_full;
	logic [47:0] num;
	logic [33:0] trial;
	logic [33:0] diff;
	logic        ge;
	logic [32:0] rem_next;
	logic signed [33:0] p_s;
	logic signed [33:0] p_sh;
	logic signed [33:0] p_sum;
	logic [15:0] dn_next;

	assign mul_a = (ucmd.op == OP_DN_MUL) ? {15'd0, ucmd.mag} : acc_q;
	assign mul_b = (ucmd.op == OP_DN_MUL) ? {16'd0, ucmd.ext} : EXP_ONE;
	assign mul_p = 64'(mul_a) * 64'(mul_b);
	assign mul_rnd = mul_p + 64'h4000_0000;

	// Denominator is one plus the exponential, numerator carries half of it for rounding.
	assign den_full = {1'b0, 32'h8000_0000} + {1'b0, acc_q};
	assign num = ucmd.pos ? (48'h8000_0000_0000 + {16'd0, den_full[32:1]})
	                      : ({acc_q, 16'd0} + {16'd0, den_full[32:1]});

	assign trial = {rem_q, num_lo_q[16]};
	assign diff = trial - {1'b0, den_q};
	assign ge = (trial >= {1'b0, den_q});
	assign rem_next = ge ? diff[32:0] : trial[32:0];

	always_comb begin
		p_s = ucmd.neg ? -$signed({2'b00, prod_q}) : $signed({2'b00, prod_q});
		p_sh = (p_s + 34'sd8192) >>> 14;
		p_sum = p_sh + $signed({{18{ucmd.min[15]}}, ucmd.min});
		if (p_sum > 34'sd32767)
			dn_next = 16'h7FFF;
		else if (p_sum < -34'sd32768)
			dn_next = 16'h8000;
		else
			dn_next = p_sum[15:0];
	end

	always_ff @(posedge clk) begin
		unique case (ucmd.op)
			OP_NOP: begin
			end
			OP_EXP_LOAD: begin
				acc_q <= ucmd.zero ? '0 : EXP_TAB[{ucmd.frac, 5'd0} +: EXP_W];
			end
			OP_EXP_MUL: begin
				acc_q <= mul_rnd[62:31];
			end
			OP_DIV_INIT: begin
				den_q <= den_full;
				rem_q <= {2'b00, num[47:17]};
				num_lo_q <= num[16:0];
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= rem_next;
				num_lo_q <= {num_lo_q[15:0], 1'b0};
				quo_q <= {quo_q[15:0], ge};
			end
			OP_DN_MUL: begin
				prod_q <= mul_p[31:0];
			end
			OP_DN_FIN: begin
				dn_q <= dn_next;
			end
			default: begin
			end
		endcase
	end

	assign ustat.quo = quo_q;
	assign ustat.dn = dn_q;

endmodule

[hw/rtl/map_query_class_filter_denorm.sv]
// ----------------------------------------------------------------------------
// Map query class filter and point denormalizer
// Scores three class logits per query, keeps or drops the query, and maps the
// normalized points of kept queries to Q8.8 metres.
// ----------------------------------------------------------------------------
// Requests enter on the item channel (item_valid / item_stall) and results
// leave on the result channel (result_valid / result_stall). A decision
// request yields one decision result. A point request yields one point result
// when the current query is kept; for a dropped query it is accepted and
// gives nothing.
// A decision request works through each of the three logits in turn (exp table
// load, final count check, divider setup, 17 divider steps, score compare),
// with one exp product step per whole unit of the logit's magnitude below 24
// through the single multiplier, then loads its result in the decide state
// once the output register is free. A point request has two multiplies and
// two rounding passes through the same unit, then the output load. A new
// request can be accepted in the cycle after a result is loaded.
// item_stall is high while a request is being worked on. A finished result
// waits in the output register; the block does not stall on a held result
// until it has the next one ready. Reset clears the request sequencer, the
// output register and the query state (no query kept) and loads the register
// defaults. Configuration writes are taken in any cycle with cfg_wr_en high.
// ----------------------------------------------------------------------------
module map_query_class_filter_denorm import mqcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        cmd,
	input  logic signed [15:0] logit_zero,
	input  logic signed [15:0] logit_one,
	input  logic signed [15:0] logit_two,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic        last_point,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        kind,
	output logic [1:0]  class_index,
	output logic [15:0] best_score,
	output logic        kept,
	output logic signed [15:0] metres_x,
	output logic signed [15:0] metres_y,
	output logic        last
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EXP_LOAD = 4'd1;
	localparam logic [3:0] S_EXP_MUL = 4'd2;
	localparam logic [3:0] S_DIV_INIT = 4'd3;
	localparam logic [3:0] S_DIV_STEP = 4'd4;
	localparam logic [3:0] S_SCORE = 4'd5;
	localparam logic [3:0] S_DECIDE = 4'd6;
	localparam logic [3:0] S_PX_MUL = 4'd7;
	localparam logic [3:0] S_PX_FIN = 4'd8;
	localparam logic [3:0] S_PY_MUL = 4'd9;
	localparam logic [3:0] S_PY_FIN = 4'd10;
	localparam logic [3:0] S_PNT_OUT = 4'd11;

	localparam logic [1:0] LAST_CLASS = 2'(CLASS_COUNT - 1);
	localparam logic [4:0] DIV_CNT_INIT = 5'(DIV_STEPS - 1);

	// Configuration registers.
	logic [15:0] thr_div_q;
	logic [15:0] thr_cross_q;
	logic [15:0] thr_bound_q;
	logic [2:0]  mask_q;
	logic [15:0] x_min_q;
	logic [15:0] y_min_q;
	logic [15:0] x_ext_q;
	logic [15:0] y_ext_q;

	// Sequencer and query state.
	logic [3:0]  state_q;
	logic [4:0]  cnt_q;
	logic [1:0]  cls_q;
	logic [1:0]  best_idx_q;
	logic [15:0] best_score_q;
	logic        query_kept_q;
	logic [1:0]  query_class_q;

	// Request payload.
	logic [15:0] logit0_q;
	logic [15:0] logit1_q;
	logic [15:0] logit2_q;
	logic [15:0] nx_q;
	logic [15:0] ny_q;
	logic        lastp_q;
	logic [15:0] mx_q;

	// Output register.
	logic        res_valid_q;
	logic        kind_q;
	logic [1:0]  class_q;
	logic [15:0] score_q;
	logic        kept_q;
	logic [15:0] mxo_q;
	logic [15:0] myo_q;
	logic        last_q;

	unit_cmd_t   ucmd;
	unit_stat_t  ustat;

	logic [15:0] logit_sel;
	logic [16:0] logit_abs;
	logic [8:0]  whole;
	logic        exp_zero;
	logic [15:0] norm_sel;
	logic [16:0] norm_abs;
	logic        use_y;
	logic [15:0] score;
	logic [15:0] thr_sel;
	logic        en_sel;
	logic        keep;
	logic        out_free;
	logic        res_load;
	logic        accept;

	assign item_stall = (state_q != S_IDLE);
	assign accept = item_valid && !item_stall;
	assign out_free = !res_valid_q || !result_stall;
	assign res_load = out_free && (state_q == S_DECIDE || state_q == S_PNT_OUT);

	always_comb begin
		unique case (cls_q)
			2'd0: logit_sel = logit0_q;
			2'd1: logit_sel = logit1_q;
			default: logit_sel = logit2_q;
		endcase
	end

	assign logit_abs = logit_sel[15] ? (17'd0 - {1'b1, logit_sel}) : {1'b0, logit_sel};
	assign whole = logit_abs[16:8];
	assign exp_zero = (whole >= EXP_CUTOFF);

	assign use_y = (state_q == S_PY_MUL) || (state_q == S_PY_FIN);
	assign norm_sel = use_y ? ny_q : nx_q;
	assign norm_abs = norm_sel[15] ? (17'd0 - {1'b1, norm_sel}) : {1'b0, norm_sel};

	// A quotient of 65536 only occurs for the largest positive logits.
	assign score = ustat.quo[16] ? 16'hFFFF : ustat.quo[15:0];

	always_comb begin
		unique case (best_idx_q)
			2'd0: begin
				thr_sel = thr_div_q;
				en_sel = mask_q[0];
			end
			2'd1: begin
				thr_sel = thr_cross_q;
				en_sel = mask_q[1];
			end
			default: begin
				thr_sel = thr_bound_q;
				en_sel = mask_q[2];
			end
		endcase
	end

	assign keep = en_sel && (best_score_q >= thr_sel);

	always_comb begin
		ucmd.op = OP_NOP;
		ucmd.frac = logit_abs[7:0];
		ucmd.zero = exp_zero;
		ucmd.pos = !logit_sel[15];
		ucmd.neg = norm_sel[15];
		ucmd.mag = norm_abs;
		ucmd.ext = use_y ? y_ext_q : x_ext_q;
		ucmd.min = use_y ? y_min_q : x_min_q;
		unique case (state_q)
			S_EXP_LOAD: ucmd.op = OP_EXP_LOAD;
			S_EXP_MUL: ucmd.op = (cnt_q != 5'd0) ? OP_EXP_MUL : OP_NOP;
			S_DIV_INIT: ucmd.op = OP_DIV_INIT;
			S_DIV_STEP: ucmd.op = OP_DIV_STEP;
			S_PX_MUL, S_PY_MUL: ucmd.op = OP_DN_MUL;
			S_PX_FIN, S_PY_FIN: ucmd.op = OP_DN_FIN;
			default: ucmd.op = OP_NOP;
		endcase
	end

	mqcf_unit u_unit (
		.clk   (clk),
		.ucmd  (ucmd),
		.ustat (ustat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_div_q <= '0;
			thr_cross_q <= '0;
			thr_bound_q <= '0;
			mask_q <= '0;
			x_min_q <= X_MINIMUM_RST;
			y_min_q <= Y_MINIMUM_RST;
			x_ext_q <= X_EXTENT_RST;
			y_ext_q <= Y_EXTENT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_THR_DIVIDER: thr_div_q <= cfg_data;
				REG_THR_CROSSING: thr_cross_q <= cfg_data;
				REG_THR_BOUNDARY: thr_bound_q <= cfg_data;
				REG_CLASS_MASK: mask_q <= cfg_data[2:0];
				REG_X_MINIMUM: x_min_q <= cfg_data;
				REG_Y_MINIMUM: y_min_q <= cfg_data;
				REG_X_EXTENT: x_ext_q <= cfg_data;
				REG_Y_EXTENT: y_ext_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			logit0_q <= logit_zero;
			logit1_q <= logit_one;
			logit2_q <= logit_two;
			nx_q <= norm_x;
			ny_q <= norm_y;
			lastp_q <= last_point;
		end
		if (state_q == S_PY_MUL)
			mx_q <= ustat.dn;
		if (state_q == S_SCORE && (cls_q == 2'd0 || score > best_score_q)) begin
			best_score_q <= score;
			best_idx_q <= cls_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			cls_q <= '0;
			query_kept_q <= 1'b0;
			query_class_q <= '0;
			res_valid_q <= 1'b0;
			kind_q <= KIND_DECISION;
			class_q <= '0;
			score_q <= '0;
			kept_q <= 1'b0;
			mxo_q <= '0;
			myo_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (res_load)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !result_stall)
				res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd == CMD_DECISION) begin
							cls_q <= '0;
							state_q <= S_EXP_LOAD;
						end else if (query_kept_q) begin
							state_q <= S_PX_MUL;
						end
					end
				end
				S_EXP_LOAD: begin
					cnt_q <= exp_zero ? 5'd0 : whole[4:0];
					state_q <= S_EXP_MUL;
				end
				S_EXP_MUL: begin
					if (cnt_q != 5'd0)
						cnt_q <= cnt_q - 5'd1;
					else
						state_q <= S_DIV_INIT;
				end
				S_DIV_INIT: begin
					cnt_q <= DIV_CNT_INIT;
					state_q <= S_DIV_STEP;
				end
				S_DIV_STEP: begin
					if (cnt_q == 5'd0)
						state_q <= S_SCORE;
					else
						cnt_q <= cnt_q - 5'd1;
				end
				S_SCORE: begin
					if (cls_q == LAST_CLASS) begin
						state_q <= S_DECIDE;
					end else begin
						cls_q <= cls_q + 2'd1;
						state_q <= S_EXP_LOAD;
					end
				end
				S_DECIDE: begin
					if (out_free) begin
						kind_q <= KIND_DECISION;
						class_q <= best_idx_q;
						score_q <= best_score_q;
						kept_q <= keep;
						mxo_q <= '0;
						myo_q <= '0;
						last_q <= 1'b0;
						query_kept_q <= keep;
						query_class_q <= best_idx_q;
						state_q <= S_IDLE;
					end
				end
				S_PX_MUL: state_q <= S_PX_FIN;
				S_PX_FIN: state_q <= S_PY_MUL;
				S_PY_MUL: state_q <= S_PY_FIN;
				S_PY_FIN: state_q <= S_PNT_OUT;
				S_PNT_OUT: begin
					if (out_free) begin
						kind_q <= KIND_POINT;
						class_q <= query_class_q;
						score_q <= '0;
						kept_q <= 1'b1;
						mxo_q <= mx_q;
						myo_q <= ustat.dn;
						last_q <= lastp_q;
						if (lastp_q)
							query_kept_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign kind = kind_q;
	assign class_index = class_q;
	assign best_score = score_q;
	assign kept = kept_q;
	assign metres_x = mxo_q;
	assign metres_y = myo_q;
	assign last = last_q;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Map query class filter testbench
// Drives decision and point requests into the filter, predicts every result
// from a local score and denormalization model with its own copy of the
// registers and query state, and checks the results in order, field by field.
// A short directed table runs first, then randomized query sequences under
// several register settings, mostly with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench import mqcf_pkg::*; ();

	localparam int unsigned CYCLE_LIMIT = 1500000;
	localparam int unsigned SETTLE_CYCLES = 160;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned RANDOM_PHASES = 6;
	localparam int unsigned PHASE_ITEMS = 280;

	typedef struct packed {
		logic        kind;
		logic [1:0]  cls;
		logic [15:0] score;
		logic        kept;
		logic [15:0] mx;
		logic [15:0] my;
		logic        last;
	} outcome_t;

	typedef enum logic {STEP_REQUEST, STEP_WRITE} step_kind_t;

	typedef struct packed {
		step_kind_t  what;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic        cmd;
		logic [15:0] l0;
		logic [15:0] l1;
		logic [15:0] l2;
		logic [15:0] nx;
		logic [15:0] ny;
		logic        lp;
		logic        pinned;
		outcome_t    want;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        cmd = 1'b0;
	logic signed [15:0] logit_zero = '0;
	logic signed [15:0] logit_one = '0;
	logic signed [15:0] logit_two = '0;
	logic signed [15:0] norm_x = '0;
	logic signed [15:0] norm_y = '0;
	logic        last_point = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        kind;
	logic [1:0]  class_index;
	logic [15:0] best_score;
	logic        kept;
	logic signed [15:0] metres_x;
	logic signed [15:0] metres_y;
	logic        last;

	// Local copy of the registers and the query state.
	logic [15:0] class_threshold [3];
	logic [2:0]  class_mask;
	logic [15:0] x_base, y_base, x_span, y_span;
	logic        held_keep;
	logic [1:0]  held_class;

	outcome_t    awaited_outputs [$];
	step_t       plan [$];
	int unsigned items_offered = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	bit          send_gaps = 1'b1;
	bit          drain_gaps = 1'b1;
	bit          hold_request = 1'b0;

	map_query_class_filter_denorm dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall),
		.cmd(cmd), .logit_zero(logit_zero), .logit_one(logit_one), .logit_two(logit_two),
		.norm_x(norm_x), .norm_y(norm_y), .last_point(last_point),
		.result_valid(result_valid), .result_stall(result_stall),
		.kind(kind), .class_index(class_index), .best_score(best_score), .kept(kept),
		.metres_x(metres_x), .metres_y(metres_y), .last(last)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// exp(-f/256) in Q1.31 from seventeen series terms, each truncated.
	function automatic longint unsigned exp_frac(input int unsigned f);
		longint          total;
		longint unsigned term;
		total = 64'sd2147483648;
		term = 64'd2147483648;
		for (int k = 1; k <= 16; k++) begin
			term = (term * f) / (256 * k);
			if (k % 2)
				total -= longint'(term);
			else
				total += longint'(term);
		end
		if (total < 0)
			total = 0;
		if (total > 64'sd2147483648)
			total = 64'sd2147483648;
		return longint'(total);
	endfunction

	function automatic logic [15:0] logit_score(input logic signed [15:0] x);
		int              xv;
		int unsigned     mag;
		int unsigned     whole;
		longint unsigned e, e_one, den, q;
		xv = x;
		mag = (xv < 0) ? -xv : xv;
		whole = mag >> 8;
		e = 0;
		if (whole < 24) begin
			e_one = exp_frac(256);
			e = exp_frac(mag & 255);
			for (int i = 0; i < whole; i++)
				e = (e * e_one + (64'd1 << 30)) >> 31;
		end
		den = (64'd1 << 31) + e;
		if (xv >= 0)
			q = ((64'd1 << 47) + den / 2) / den;
		else
			q = ((e << 16) + den / 2) / den;
		if (q > 65535)
			q = 65535;
		return q[15:0];
	endfunction

	// Scale by the span, round half up out of Q10.22, add the base, saturate.
	function automatic logic [15:0] to_metres(input logic signed [15:0] nrm,
		input logic [15:0] span, input logic signed [15:0] base);
		longint sv, ev, v;
		sv = nrm;
		ev = span;
		v = (sv * ev + 8192) >>> 14;
		v = v + base;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	function automatic outcome_t decision_outcome(input logic [1:0] cls,
		input logic [15:0] score, input logic keep);
		return {KIND_DECISION, cls, score, keep, 16'd0, 16'd0, 1'b0};
	endfunction

	function automatic outcome_t point_outcome(input logic [1:0] cls,
		input logic [15:0] mx, input logic [15:0] my, input logic lp);
		return {KIND_POINT, cls, 16'd0, 1'b1, mx, my, lp};
	endfunction

	// Works out what an accepted request yields and updates the query state.
	task automatic forecast_request(input logic c, input logic [15:0] a, b, d, x, y,
		input logic lp, input logic pinned, input outcome_t want);
		logic [15:0] score [3];
		int          best;
		logic        keep;
		outcome_t    fore;
		bit          yields;
		yields = 1'b0;
		if (c == CMD_DECISION) begin
			score[0] = logit_score(a);
			score[1] = logit_score(b);
			score[2] = logit_score(d);
			best = 0;
			for (int k = 1; k < 3; k++)
				if (score[k] > score[best])
					best = k;
			keep = class_mask[best] && score[best] >= class_threshold[best];
			held_keep = keep;
			held_class = best[1:0];
			fore = decision_outcome(best[1:0], score[best], keep);
			yields = 1'b1;
		end else if (held_keep) begin
			fore = point_outcome(held_class, to_metres(x, x_span, x_base),
				to_metres(y, y_span, y_base), lp);
			if (lp)
				held_keep = 1'b0;
			yields = 1'b1;
		end
		if (yields)
			awaited_outputs.insert(awaited_outputs.size(), pinned ? want : fore);
	endtask

	task automatic offer(input logic c, input logic [15:0] a, b, d, x, y,
		input logic lp, input logic pinned, input outcome_t want);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd <= c;
		logit_zero <= a;
		logit_one <= b;
		logit_two <= d;
		norm_x <= x;
		norm_y <= y;
		last_point <= lp;
		do @(posedge clk); while (!(item_valid && !item_stall));
		items_offered++;
		forecast_request(c, a, b, d, x, y, lp, pinned, want);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_THR_DIVIDER:  class_threshold[0] = val;
			REG_THR_CROSSING: class_threshold[1] = val;
			REG_THR_BOUNDARY: class_threshold[2] = val;
			REG_CLASS_MASK:   class_mask = val[2:0];
			REG_X_MINIMUM:    x_base = val;
			REG_Y_MINIMUM:    y_base = val;
			REG_X_EXTENT:     x_span = val;
			REG_Y_EXTENT:     y_span = val;
			default: ;
		endcase
	endtask

	// Dropped points leave nothing to wait for, so allow the block to finish
	// whatever it may still be working on.
	task automatic settle();
		item_valid <= 1'b0;
		while (awaited_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic plan_request(input logic c, input logic [15:0] a, b, d, x, y,
		input logic lp);
		plan.insert(plan.size(), step_t'({STEP_REQUEST, 3'd0, 16'd0, c, a, b, d, x, y,
			lp, 1'b0, outcome_t'(0)}));
	endtask

	task automatic plan_pinned(input logic c, input logic [15:0] a, b, d, x, y,
		input logic lp, input outcome_t want);
		plan.insert(plan.size(), step_t'({STEP_REQUEST, 3'd0, 16'd0, c, a, b, d, x, y,
			lp, 1'b1, want}));
	endtask

	task automatic plan_write(input logic [2:0] idx, input logic [15:0] val);
		plan.insert(plan.size(), step_t'({STEP_WRITE, idx, val, 1'b0, 16'd0, 16'd0,
			16'd0, 16'd0, 16'd0, 1'b0, 1'b0, outcome_t'(0)}));
	endtask

	function automatic logic [15:0] pick_logit();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, 12800)) - 16'd6400;
			6, 7: return 16'($urandom);
			default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		endcase
	endfunction

	function automatic logic [15:0] pick_norm();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, 40000)) - 16'd20000;
			6, 7: return 16'($urandom);
			8: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
		endcase
	endfunction

	function automatic logic [15:0] pick_threshold();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 60000));
		endcase
	endfunction

	function automatic logic [15:0] pick_base();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom_range(0, 16000)) - 16'd8000;
		endcase
	endfunction

	function automatic logic [15:0] pick_span();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			default: return 16'($urandom_range(1, 20000));
		endcase
	endfunction

	task automatic setup_phase();
		logic [2:0] mask;
		mask = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd7;
		write_reg(REG_THR_DIVIDER, pick_threshold());
		write_reg(REG_THR_CROSSING, pick_threshold());
		write_reg(REG_THR_BOUNDARY, pick_threshold());
		write_reg(REG_CLASS_MASK, (16'($urandom) & 16'hFFF8) | {13'd0, mask});
		write_reg(REG_X_MINIMUM, pick_base());
		write_reg(REG_Y_MINIMUM, pick_base());
		write_reg(REG_X_EXTENT, pick_span());
		write_reg(REG_Y_EXTENT, pick_span());
	endtask

	// Mostly a decision request followed by its points; now and then a stray
	// point, a query without points or a misplaced end-of-query mark.
	task automatic random_query();
		int          npts;
		logic        lp;
		logic [15:0] a, b, d;
		if ($urandom_range(0, 9) == 0) begin
			offer(CMD_POINT, 16'($urandom), 16'($urandom), 16'($urandom), pick_norm(),
				pick_norm(), 1'($urandom_range(0, 1)), 1'b0, outcome_t'(0));
			return;
		end
		a = pick_logit();
		b = ($urandom_range(0, 7) == 0) ? a : pick_logit();
		d = ($urandom_range(0, 7) == 0) ? b : pick_logit();
		offer(CMD_DECISION, a, b, d, 16'($urandom), 16'($urandom),
			1'($urandom_range(0, 1)), 1'b0, outcome_t'(0));
		npts = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
		for (int i = 0; i < npts; i++) begin
			lp = (i == npts - 1);
			if ($urandom_range(0, 19) == 0)
				lp = ~lp;
			offer(CMD_POINT, 16'($urandom), 16'($urandom), 16'($urandom), pick_norm(),
				pick_norm(), lp, 1'b0, outcome_t'(0));
		end
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	task automatic check_result(input outcome_t want);
		compare_field("kind", 16'(want.kind), 16'(kind));
		compare_field("class_index", 16'(want.cls), 16'(class_index));
		compare_field("best_score", want.score, best_score);
		compare_field("kept", 16'(want.kept), 16'(kept));
		compare_field("metres_x", want.mx, metres_x);
		compare_field("metres_y", want.my, metres_y);
		compare_field("last", 16'(want.last), 16'(last));
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_outputs.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, expected none, actual kind %h class %h",
					$time, kind, class_index);
			end else begin
				check_result(awaited_outputs.pop_front());
			end
		end
	end

	// Result side: random stall bursts, and one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (drain_gaps && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		bit          dirty;
		int unsigned start;
		class_threshold[0] = 16'd0;
		class_threshold[1] = 16'd0;
		class_threshold[2] = 16'd0;
		class_mask = 3'd0;
		x_base = X_MINIMUM_RST;
		y_base = Y_MINIMUM_RST;
		x_span = X_EXTENT_RST;
		y_span = Y_EXTENT_RST;
		held_keep = 1'b0;
		held_class = 2'd0;

		// Reset defaults: no class enabled, so every query is dropped.
		plan_pinned(CMD_DECISION, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
			decision_outcome(2'd0, 16'h8000, 1'b0));
		plan_request(CMD_POINT, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h4000, 1'b1);
		plan_pinned(CMD_DECISION, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b0,
			decision_outcome(2'd0, 16'hFFFF, 1'b0));
		plan_pinned(CMD_DECISION, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1,
			decision_outcome(2'd0, 16'h0000, 1'b0));
		plan_pinned(CMD_DECISION, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b0,
			decision_outcome(2'd1, 16'hFFFF, 1'b0));
		plan_pinned(CMD_DECISION, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0,
			decision_outcome(2'd2, 16'hFFFF, 1'b0));
		// All classes enabled with zero thresholds, default ranges.
		plan_write(REG_CLASS_MASK, 16'h0007);
		plan_pinned(CMD_DECISION, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0,
			decision_outcome(2'd2, 16'hFFFF, 1'b1));
		plan_pinned(CMD_POINT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
			point_outcome(2'd2, 16'hF100, 16'hE200, 1'b0));
		plan_pinned(CMD_POINT, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h4000, 1'b0,
			point_outcome(2'd2, 16'h0F00, 16'h1E00, 1'b0));
		plan_pinned(CMD_POINT, 16'h0000, 16'h0000, 16'h0000, 16'hC000, 16'hC000, 1'b1,
			point_outcome(2'd2, 16'hD300, 16'hA600, 1'b1));
		// The query ended with the last point, so this one is dropped.
		plan_request(CMD_POINT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		plan_request(CMD_DECISION, 16'h0000, 16'h0100, 16'hFF00, 16'h0000, 16'h0000, 1'b0);
		plan_request(CMD_POINT, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 1'b0);
		plan_request(CMD_POINT, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 1'b1);
		// Highest thresholds: only a saturated score passes.
		plan_write(REG_THR_DIVIDER, 16'hFFFF);
		plan_write(REG_THR_CROSSING, 16'hFFFF);
		plan_write(REG_THR_BOUNDARY, 16'hFFFF);
		plan_write(REG_X_EXTENT, 16'h0000);
		plan_write(REG_Y_EXTENT, 16'h0001);
		plan_pinned(CMD_DECISION, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
			decision_outcome(2'd0, 16'hFFFF, 1'b1));
		plan_request(CMD_POINT, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b1);
		plan_pinned(CMD_DECISION, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
			decision_outcome(2'd0, 16'h8000, 1'b0));
		plan_request(CMD_POINT, 16'h0000, 16'h0000, 16'h0000, 16'h1234, 16'h4321, 1'b1);
		// A disabled winning class drops the query whatever its score.
		plan_write(REG_THR_CROSSING, 16'h0000);
		plan_write(REG_CLASS_MASK, 16'h0005);
		plan_pinned(CMD_DECISION, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0,
			decision_outcome(2'd1, 16'hFFFF, 1'b0));
		plan_request(CMD_POINT, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h4000, 1'b0);
		// Wide spans and extreme bases saturate the metres.
		plan_write(REG_THR_DIVIDER, 16'h0000);
		plan_write(REG_THR_BOUNDARY, 16'h0000);
		plan_write(REG_CLASS_MASK, 16'h0007);
		plan_write(REG_X_MINIMUM, 16'h8000);
		plan_write(REG_Y_MINIMUM, 16'h7FFF);
		plan_write(REG_X_EXTENT, 16'hFFFF);
		plan_write(REG_Y_EXTENT, 16'h8000);
		plan_request(CMD_DECISION, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		plan_request(CMD_POINT, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b0);
		plan_request(CMD_POINT, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 1'b0);
		plan_request(CMD_POINT, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 1'b1);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		dirty = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].what == STEP_WRITE) begin
				if (dirty)
					settle();
				dirty = 1'b0;
				write_reg(plan[i].reg_index, plan[i].reg_value);
			end else begin
				offer(plan[i].cmd, plan[i].l0, plan[i].l1, plan[i].l2, plan[i].nx,
					plan[i].ny, plan[i].lp, plan[i].pinned, plan[i].want);
				dirty = 1'b1;
			end
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			send_gaps = (phase != 2 && phase != RANDOM_PHASES - 1);
			drain_gaps = send_gaps;
			settle();
			setup_phase();
			if (phase == 1)
				hold_request = 1'b1;
			start = items_offered;
			while (items_offered - start < PHASE_ITEMS)
				random_query();
		end

		settle();
		if (error_count == 0 && awaited_outputs.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
